@@ src/ibspm_pkg.sv @@
package ibspm_pkg;

  localparam int ID_BITS     = 16;
  localparam int WB          = ID_BITS - 5;                // bitmap word index bits
  localparam int WORD_COUNT  = 2 ** WB;
  localparam int SB          = (WB > 5) ? WB - 5 : 1;      // summary word index bits
  localparam int PWB         = SB + 5;                     // word index padded to summary split
  localparam int TOP_N       = 2 ** SB;                    // summary words
  localparam int TOP_CHUNKS  = (TOP_N + 31) / 32;          // 32-bit chunks of the top vector
  localparam int CB          = (TOP_CHUNKS > 1) ? $clog2(TOP_CHUNKS) : 1;
  localparam int TOP_W       = TOP_CHUNKS * 32;

  localparam logic [1:0] CMD_MARK = 2'd0;
  localparam logic [1:0] CMD_TEST = 2'd1;
  localparam logic [1:0] CMD_POP  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] id;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic        is_set;
    logic [15:0] popped_id;
    logic        empty_res;
  } rsp_t;

  typedef struct packed {
    logic       found;
    logic [4:0] pos;
  } ffs_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_TEST,
    S_SCAN,
    S_SUM,
    S_BIT,
    S_OUT
  } state_e;

endpackage

@@ src/ibspm_ram.sv @@
module ibspm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/ibspm_ffs.sv @@
module ibspm_ffs (
  input  logic [31:0]         word,
  output ibspm_pkg::ffs_t     res
);
  import ibspm_pkg::*;

  // lowest set bit wins
  always_comb begin
    res.found = |word;
    res.pos   = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (word[i]) begin
        res.pos = 5'(i);
      end
    end
  end

endmodule

@@ src/id_bitmap_set_pop_min_unit.sv @@
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_stall | cmd, id
// rsp     | out       | rsp_valid, rsp_stall | kind, is_set, popped_id, empty_res
//
// Mark reads the summary and bitmap words and writes them back; test reads
// them and goes to the output state; a pop scans the top summary vector one
// 32-bit chunk at a time, then finds the lowest set bit of the summary word
// and then of the bitmap word, using the shared find-first-set unit and the
// registered RAM reads, or reports an empty set after the last chunk.
// Reset clears the top summary vector but not the RAMs; no clearing pass is needed.
// A finished result sits in the rsp register while the next request is taken;
// a second result waits in the output state until rsp is free.
module id_bitmap_set_pop_min_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  ibspm_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ibspm_pkg::rsp_t   rsp
);
  import ibspm_pkg::*;

  state_e               state, state_next;
  logic [ID_BITS-1:0]   id_hold, id_hold_next;
  logic [CB-1:0]        cnt, cnt_next;
  logic [SB-1:0]        s_hold, s_hold_next;
  logic [4:0]           sb_hold, sb_hold_next;
  logic [31:0]          sum_hold, sum_hold_next;
  rsp_t                 res, res_next;
  logic [TOP_W-1:0]     top;

  logic                 accept;
  logic [ID_BITS-1:0]   id_cur;
  logic [PWB-1:0]       w_pad;
  logic [SB-1:0]        mk_s;
  logic [4:0]           mk_sb;
  logic [4:0]           mk_b;
  logic [CB+4:0]        scan_full;
  logic [SB-1:0]        scan_s;
  logic [PWB-1:0]       pop_w;
  logic [PWB+4:0]       found_full;
  logic [31:0]          sum_word;
  logic                 word_ok;
  logic [31:0]          bm_word;
  logic [31:0]          new_bm;
  logic [31:0]          new_sum;

  logic                 sum_we;
  logic [SB-1:0]        sum_waddr;
  logic [31:0]          sum_wdata;
  logic [SB-1:0]        sum_raddr;
  logic [31:0]          sum_rd;
  logic                 bm_we;
  logic [WB-1:0]        bm_waddr;
  logic [31:0]          bm_wdata;
  logic [WB-1:0]        bm_raddr;
  logic [31:0]          bm_rd;

  logic [31:0]          ffs_in;
  ffs_t                 ffs;
  logic                 top_set;
  logic                 top_clr;
  logic                 rsp_load;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // address split for mark and test
  assign id_cur = (state == S_IDLE) ? ID_BITS'(req.id) : id_hold;
  assign w_pad  = PWB'(id_cur[ID_BITS-1:5]);
  assign mk_s   = w_pad[PWB-1:5];
  assign mk_sb  = w_pad[4:0];
  assign mk_b   = id_cur[4:0];

  assign scan_full  = {cnt, ffs.pos};
  assign scan_s     = SB'(scan_full);
  assign pop_w      = {s_hold, (state == S_SUM) ? ffs.pos : sb_hold};
  assign found_full = {s_hold, sb_hold, ffs.pos};

  // a word is only trusted when the level above says it is non-empty
  assign sum_word = top[mk_s] ? sum_rd : 32'd0;
  assign word_ok  = sum_word[mk_sb];
  assign bm_word  = word_ok ? bm_rd : 32'd0;
  assign new_bm   = bm_rd & ~(32'd1 << ffs.pos);
  assign new_sum  = sum_hold & ~(32'd1 << sb_hold);

  assign sum_raddr = (state == S_SCAN) ? scan_s : mk_s;
  assign bm_raddr  = (state == S_SUM) ? pop_w[WB-1:0] : w_pad[WB-1:0];

  always_comb begin
    unique case (state)
      S_SCAN:  ffs_in = top[{cnt, 5'd0} +: 32];
      S_SUM:   ffs_in = sum_rd;
      S_BIT:   ffs_in = bm_rd;
      default: ffs_in = 32'd0;
    endcase
  end

  ibspm_ffs u_ffs (
    .word (ffs_in),
    .res  (ffs)
  );

  ibspm_ram #(.WIDTH(32), .DEPTH(TOP_N)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rd)
  );

  ibspm_ram #(.WIDTH(32), .DEPTH(WORD_COUNT)) u_bm_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      top       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (top_set) begin
        top[mk_s] <= 1'b1;
      end
      if (top_clr) begin
        top[s_hold] <= 1'b0;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_hold  <= id_hold_next;
    cnt      <= cnt_next;
    s_hold   <= s_hold_next;
    sb_hold  <= sb_hold_next;
    sum_hold <= sum_hold_next;
    res      <= res_next;
    if (rsp_load) begin
      rsp <= res;
    end
  end

  always_comb begin
    state_next    = state;
    id_hold_next  = id_hold;
    cnt_next      = cnt;
    s_hold_next   = s_hold;
    sb_hold_next  = sb_hold;
    sum_hold_next = sum_hold;
    res_next      = res;
    sum_we        = 1'b0;
    sum_waddr     = mk_s;
    sum_wdata     = sum_word | (32'd1 << mk_sb);
    bm_we         = 1'b0;
    bm_waddr      = w_pad[WB-1:0];
    bm_wdata      = bm_word | (32'd1 << mk_b);
    top_set       = 1'b0;
    top_clr       = 1'b0;
    rsp_load      = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          id_hold_next = ID_BITS'(req.id);
          cnt_next     = '0;
          unique case (req.cmd)
            CMD_MARK: state_next = S_MARK;
            CMD_TEST: state_next = S_TEST;
            CMD_POP:  state_next = S_SCAN;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_MARK: begin
        bm_we      = 1'b1;
        sum_we     = 1'b1;
        top_set    = 1'b1;
        state_next = S_IDLE;
      end
      S_TEST: begin
        res_next.kind      = 1'b0;
        res_next.is_set    = word_ok & bm_word[mk_b];
        res_next.popped_id = 16'd0;
        res_next.empty_res = 1'b0;
        state_next         = S_OUT;
      end
      S_SCAN: begin
        if (ffs.found) begin
          s_hold_next = scan_s;
          state_next  = S_SUM;
        end else if (cnt == CB'(TOP_CHUNKS - 1)) begin
          res_next.kind      = 1'b1;
          res_next.is_set    = 1'b0;
          res_next.popped_id = 16'hFFFF;
          res_next.empty_res = 1'b1;
          state_next         = S_OUT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SUM: begin
        sum_hold_next = sum_rd;
        sb_hold_next  = ffs.pos;
        state_next    = S_BIT;
      end
      S_BIT: begin
        bm_we     = 1'b1;
        bm_waddr  = pop_w[WB-1:0];
        bm_wdata  = new_bm;
        sum_waddr = s_hold;
        sum_wdata = new_sum;
        // drop the summary bit once its word empties, and the top bit likewise
        if (new_bm == 32'd0) begin
          sum_we  = 1'b1;
          top_clr = (new_sum == 32'd0);
        end
        res_next.kind      = 1'b1;
        res_next.is_set    = 1'b0;
        res_next.popped_id = 16'(found_full[ID_BITS-1:0]);
        res_next.empty_res = 1'b0;
        state_next         = S_OUT;
      end
      S_OUT: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ src/ibspm_checker.sv @@
module ibspm_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input ibspm_pkg::req_t   req,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input ibspm_pkg::rsp_t   rsp
);
  import ibspm_pkg::*;

  // every accepted mark, test or pop leaves the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall &&
    (req.cmd == CMD_MARK || req.cmd == CMD_TEST || req.cmd == CMD_POP) |=> req_stall)
    else $error("request taken on back-to-back cycles");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind && rsp.empty_res |-> rsp.popped_id == 16'hFFFF && !rsp.is_set)
    else $error("empty pop with bad id");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("not idle after reset");

endmodule

bind id_bitmap_set_pop_min_unit ibspm_checker u_ibspm_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

typedef enum bit {
  KIND_TEST = 1'b0,
  KIND_POP  = 1'b1
} result_kind_e;

class set_scoreboard;
  bit [31:0] marks [ibspm_pkg::WORD_COUNT];
  ibspm_pkg::rsp_t answers [$];
  int errors;

  function int pending();
    return answers.size();
  endfunction

  // Update the id set for one accepted transaction and queue its answer, if it has one.
  function void note_request(ibspm_pkg::req_t r);
    int unsigned id_w;
    int unsigned word;
    int unsigned w;
    int unsigned b;
    ibspm_pkg::rsp_t res;
    id_w = r.id & ((32'd1 << ibspm_pkg::ID_BITS) - 1);
    word = (id_w >> 5) % ibspm_pkg::WORD_COUNT;
    b = id_w & 32'h1f;
    res = '0;
    case (r.cmd)
      ibspm_pkg::CMD_MARK: marks[word][b] = 1'b1;
      ibspm_pkg::CMD_TEST: begin
        res.kind = KIND_TEST;
        res.is_set = marks[word][b];
        answers.push_back(res);
      end
      ibspm_pkg::CMD_POP: begin
        res.kind = KIND_POP;
        res.popped_id = 16'hFFFF;
        res.empty_res = 1'b1;
        for (w = 0; w < ibspm_pkg::WORD_COUNT; w++) begin
          if (marks[w] != 32'd0) begin
            for (b = 0; b < 32; b++) begin
              if (marks[w][b]) break;
            end
            marks[w][b] = 1'b0;
            res.popped_id = 16'((w << 5) | b);
            res.empty_res = 1'b0;
            break;
          end
        end
        answers.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(ibspm_pkg::rsp_t got);
    ibspm_pkg::rsp_t want;
    if (answers.size() == 0) begin
      $error("result with no transaction waiting: %p", got);
      errors++;
      return;
    end
    want = answers.pop_front();
    check_field("kind", 16'(want.kind), 16'(got.kind));
    check_field("is_set", 16'(want.is_set), 16'(got.is_set));
    check_field("popped_id", want.popped_id, got.popped_id);
    check_field("empty_res", 16'(want.empty_res), 16'(got.empty_res));
  endfunction
endclass

module testbench;
  import ibspm_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 600;
  localparam int IDLE_PCT     = 14;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  set_scoreboard sb = new;
  bit quiet = 1'b0;
  bit hold_on = 1'b0;
  bit hold_done = 1'b0;
  int cycles = 0;

  id_bitmap_set_pop_min_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) sb.note_request(req);
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("timeout with %0d results outstanding", sb.pending());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off so the unit backs up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_on && !hold_done) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Mix low ids, ids near the top of the space and ids anywhere.
  function automatic logic [15:0] pick_id();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) return 16'($urandom_range(255));
    if (sel < 70) return 16'($urandom_range(16'hFFFF, 16'hFF00));
    return 16'($urandom);
  endfunction

  task automatic offer(input logic [1:0] cmd, input logic [15:0] id);
    req_t item;
    item.cmd = cmd;
    item.id = id;
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall);
    if (!quiet && !(hold_on && !hold_done) && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  initial begin
    int n;
    int r;
    bit pop_heavy;
    logic [1:0] cmd;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty set, both ends of the id space, repeated mark, unused command.
    offer(CMD_TEST, 16'h0000);
    offer(CMD_POP, 16'h0000);
    offer(CMD_MARK, 16'hFFFF);
    offer(CMD_TEST, 16'hFFFF);
    offer(CMD_TEST, 16'hFFFE);
    offer(CMD_MARK, 16'h0000);
    offer(CMD_MARK, 16'h0000);
    offer(CMD_TEST, 16'h0000);
    offer(CMD_UNUSED, 16'h1234);
    offer(CMD_TEST, 16'h1234);
    offer(CMD_MARK, 16'd31);
    offer(CMD_MARK, 16'd32);
    offer(CMD_MARK, 16'h5555);
    offer(CMD_MARK, 16'hAAAA);
    // Drain in ascending order, across word boundaries, then pop once more.
    repeat (7) offer(CMD_POP, 16'hFFFF);
    offer(CMD_TEST, 16'h0000);
    offer(CMD_UNUSED, 16'hFFFF);
    offer(CMD_TEST, 16'hFFFF);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      quiet = (n >= 300 && n < 400);
      if (n == 100) hold_on = 1'b1;
      // Alternate growing and draining the set so pops also find it empty.
      pop_heavy = ((n / 100) % 2) == 1;
      r = $urandom_range(99);
      if (r < (pop_heavy ? 20 : 45)) cmd = CMD_MARK;
      else if (r < (pop_heavy ? 45 : 70)) cmd = CMD_TEST;
      else if (r < 95) cmd = CMD_POP;
      else cmd = CMD_UNUSED;
      offer(cmd, pick_id());
      if (cmd != CMD_UNUSED) n++;
    end
    quiet = 1'b0;
    req_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
src/ibspm_pkg.sv
src/ibspm_ram.sv
src/ibspm_ffs.sv
src/id_bitmap_set_pop_min_unit.sv
src/ibspm_checker.sv
dv/testbench.sv
